/* hdl/bpfa_pkg.sv */
package bpfa_pkg;

  // Bitmap geometry: used bits are kept as rows of WORD_W bits
  localparam int PAGES  = 4096;
  localparam int PAGE_W = 12;
  localparam int CNT_W  = 13;
  localparam int WORD_W = 64;
  localparam int BIT_W  = $clog2(WORD_W);
  localparam int ROWS   = PAGES / WORD_W;
  localparam int ROW_W  = $clog2(ROWS);

  typedef enum logic [1:0] {
    CMD_ALLOC_ANY = 2'd0,
    CMD_FREE      = 2'd1,
    CMD_ALLOC_AT  = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_OOM          = 3'd1,
    ST_RANGE        = 3'd2,
    ST_KERNEL       = 3'd3,
    ST_IN_USE       = 3'd4,
    ST_ALREADY_FREE = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    OP_IDLE       = 4'd0,
    OP_START      = 4'd1,
    OP_SCAN_FIRST = 4'd2,
    OP_SCAN_NEXT  = 4'd3,
    OP_FOUND      = 4'd4,
    OP_ALLOC      = 4'd5,
    OP_FREE       = 4'd6,
    OP_REFUSE     = 4'd7,
    OP_OUT        = 4'd8
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t status;
  } dp_ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic bit_used;
    logic ge_kernel;
    logic row_full;
    logic row_last;
    logic out_free;
  } dp_sts_t;

endpackage

/* hdl/bpfa_ctrl.sv */
module bpfa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bpfa_pkg::dp_sts_t sts,
  output bpfa_pkg::dp_ctl_t ctl
);
  import bpfa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl.op     = OP_IDLE;
    ctl.status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.op     = OP_START;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        state_next = S_DONE;
        unique case (sts.cmd)
          CMD_FREE: begin
            priority if (sts.bit_used) begin
              ctl.op = OP_FREE;
            end else begin
              ctl.op     = OP_REFUSE;
              ctl.status = ST_ALREADY_FREE;
            end
          end
          CMD_ALLOC_AT: begin
            priority if (sts.ge_kernel) begin
              ctl.op     = OP_REFUSE;
              ctl.status = ST_KERNEL;
            end else if (sts.bit_used) begin
              ctl.op     = OP_REFUSE;
              ctl.status = ST_IN_USE;
            end else begin
              ctl.op = OP_ALLOC;
            end
          end
          CMD_ALLOC_ANY: begin
            // taken hint page falls back to a scan from page 1
            priority if (sts.bit_used) begin
              ctl.op     = OP_SCAN_FIRST;
              state_next = S_SCAN;
            end else if (sts.ge_kernel) begin
              ctl.op     = OP_REFUSE;
              ctl.status = ST_KERNEL;
            end else begin
              ctl.op = OP_ALLOC;
            end
          end
          CMD_NONE: begin
            ctl.op     = OP_REFUSE;
            ctl.status = ST_RANGE;
          end
        endcase
      end
      S_SCAN: begin
        priority if (!sts.row_full) begin
          ctl.op     = OP_FOUND;
          state_next = S_LOOK;
        end else if (sts.row_last) begin
          ctl.op     = OP_REFUSE;
          ctl.status = ST_OOM;
          state_next = S_DONE;
        end else begin
          ctl.op = OP_SCAN_NEXT;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready = (state == S_IDLE);

`ifndef SYNTHESIS
  a_start_to_look: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_LOOK))
    else $error("accepted word did not reach lookup");

  a_scan_leaves: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && sts.row_full && sts.row_last) |=> (state == S_DONE))
    else $error("scan ran past last row");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !sts.out_free) |=> (state == S_DONE))
    else $error("result dropped while output busy");
`endif

endmodule

/* hdl/bpfa_dp.sv */
module bpfa_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [bpfa_pkg::CNT_W-1:0]  cfg_data,
  input  logic [1:0]                  in_cmd,
  input  logic [bpfa_pkg::PAGE_W-1:0] in_page,
  input  bpfa_pkg::dp_ctl_t           ctl,
  output bpfa_pkg::dp_sts_t           sts,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [bpfa_pkg::PAGE_W-1:0] page_out,
  output logic [2:0]                  status,
  output logic [bpfa_pkg::CNT_W-1:0]  free_count,
  output logic [bpfa_pkg::CNT_W-1:0]  used_count
);
  import bpfa_pkg::*;

  // used-bit rows; rows never written read as all free via row_vld
  logic [WORD_W-1:0] mem [ROWS];
  logic [ROWS-1:0]   row_vld;
  logic [WORD_W-1:0] rd_data;
  logic              rd_vld;

  logic [CNT_W-1:0]  kfp;
  logic [PAGE_W-1:0] hint;
  logic [CNT_W-1:0]  free_total;
  logic [CNT_W-1:0]  used_total;

  cmd_t              cmd_q;
  logic [PAGE_W-1:0] tgt;
  logic [ROW_W-1:0]  scan_row;
  logic [PAGE_W-1:0] res_page;
  status_t           res_status;

  logic [PAGE_W-1:0] hint_base;
  logic [PAGE_W-1:0] hint_inc;
  logic              rd_en;
  logic [ROW_W-1:0]  rd_addr;
  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] scan_word;
  logic [BIT_W-1:0]  pos;
  logic [WORD_W-1:0] onehot;
  logic              wr_en;
  logic [WORD_W-1:0] wr_data;

  // next-fit: pull hint back to 1 at kernel boundary or top page, then step
  always_comb begin
    if (({1'b0, hint} >= kfp) || (hint >= PAGE_W'(PAGES - 1))) begin
      hint_base = PAGE_W'(1);
    end else begin
      hint_base = hint;
    end
    hint_inc = hint_base + PAGE_W'(1);
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (ctl.op)
      OP_START: begin
        rd_en = 1'b1;
        if (cmd_t'(in_cmd) == CMD_ALLOC_ANY) begin
          rd_addr = hint_inc[PAGE_W-1 -: ROW_W];
        end else begin
          rd_addr = in_page[PAGE_W-1 -: ROW_W];
        end
      end
      OP_SCAN_FIRST: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      OP_SCAN_NEXT: begin
        rd_en   = 1'b1;
        rd_addr = scan_row + ROW_W'(1);
      end
      default: ;
    endcase
  end

  assign word = rd_vld ? rd_data : '0;
  // page 0 never comes out of a scan
  assign scan_word = word | ((scan_row == '0) ? WORD_W'(1) : '0);

  always_comb begin
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!scan_word[i]) begin
        pos = BIT_W'(i);
      end
    end
  end

  assign onehot  = WORD_W'(1) << tgt[BIT_W-1:0];
  assign wr_en   = (ctl.op == OP_ALLOC) || (ctl.op == OP_FREE);
  assign wr_data = (ctl.op == OP_ALLOC) ? (word | onehot) : (word & ~onehot);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tgt[PAGE_W-1 -: ROW_W]] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld[tgt[PAGE_W-1 -: ROW_W]] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= row_vld[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kfp        <= CNT_W'(4096);
      hint       <= PAGE_W'(1);
      free_total <= CNT_W'(PAGES);
      used_total <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        kfp <= cfg_data;
      end
      unique case (ctl.op)
        OP_START: begin
          if (cmd_t'(in_cmd) == CMD_ALLOC_ANY) begin
            hint <= hint_inc;
          end
        end
        OP_FOUND: hint <= {scan_row, pos};
        OP_ALLOC: begin
          hint       <= tgt;
          free_total <= free_total - CNT_W'(1);
          used_total <= used_total + CNT_W'(1);
        end
        OP_FREE: begin
          free_total <= free_total + CNT_W'(1);
          used_total <= used_total - CNT_W'(1);
        end
        default: ;
      endcase
      if (ctl.op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_START: begin
        cmd_q <= cmd_t'(in_cmd);
        if (cmd_t'(in_cmd) == CMD_ALLOC_ANY) begin
          tgt <= hint_inc;
        end else begin
          tgt <= in_page;
        end
      end
      OP_SCAN_FIRST: scan_row <= '0;
      OP_SCAN_NEXT:  scan_row <= scan_row + ROW_W'(1);
      OP_FOUND:      tgt <= {scan_row, pos};
      OP_ALLOC, OP_FREE: begin
        res_page   <= tgt;
        res_status <= ST_OK;
      end
      OP_REFUSE: begin
        res_page   <= '0;
        res_status <= ctl.status;
      end
      OP_OUT: begin
        page_out   <= res_page;
        status     <= res_status;
        free_count <= free_total;
        used_count <= used_total;
      end
      default: ;
    endcase
  end

  assign sts.cmd       = cmd_q;
  assign sts.bit_used  = word[tgt[BIT_W-1:0]];
  assign sts.ge_kernel = ({1'b0, tgt} >= kfp);
  assign sts.row_full  = &scan_word;
  assign sts.row_last  = (scan_row == ROW_W'(ROWS - 1));
  assign sts.out_free  = !out_valid || out_ready;

`ifndef SYNTHESIS
  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    (({1'b0, free_total} + {1'b0, used_total}) == (CNT_W + 1)'(PAGES)))
    else $error("free and used counts disagree");

  a_alloc_update: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_ALLOC) |=>
      (used_total == $past(used_total) + CNT_W'(1)) && (hint == $past(tgt)))
    else $error("allocation did not update count and hint");

  a_out_slot: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_OUT) |-> (!out_valid || out_ready))
    else $error("output register overwritten");
`endif

endmodule

/* hdl/bitmap_page_frame_allocator.sv */
// Bitmap page-frame allocator, next-fit hint, 64-bit bitmap rows.
// Sequence: lookup state, done state, then out_valid when no scan is needed;
//   a scan reads one row per cycle (up to 64) and then re-runs the lookup.
// Throughput: one word at a time, next word taken while out_valid is first high;
//   a held output word stalls the next word in its done state.
// Reset (sync, rst high): all pages free, hint 1, kernel boundary 4096, no clearing pass.
module bitmap_page_frame_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [bpfa_pkg::CNT_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  cmd,
  input  logic [bpfa_pkg::PAGE_W-1:0] page_num,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bpfa_pkg::PAGE_W-1:0] page_out,
  output logic [2:0]                  status,
  output logic [bpfa_pkg::CNT_W-1:0]  free_count,
  output logic [bpfa_pkg::CNT_W-1:0]  used_count
);
  import bpfa_pkg::*;

  // controller sequences lookup / scan / update; datapath owns the bitmap,
  // hint, counters and the output word register
  dp_ctl_t ctl;
  dp_sts_t sts;

  bpfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  bpfa_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_cmd     (cmd),
    .in_page    (page_num),
    .ctl        (ctl),
    .sts        (sts),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .page_out   (page_out),
    .status     (status),
    .free_count (free_count),
    .used_count (used_count)
  );

endmodule

/* tb/sv/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bpfa_pkg::*;

  localparam int     CLK_HALF     = 6;
  localparam int     RESET_CYCLES = 9;
  // Outlasts a full scan of all bitmap rows
  localparam int     SETTLE_CYCLES = 100;
  localparam int     IDLE_GUARD   = 4;
  localparam int     FILL_PAGES   = 640;
  localparam longint CYCLE_LIMIT  = 4_000_000;
  localparam int     SHOW_MAX     = 10;

  // One result word as the block should present it
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    status_t           st;
    logic [CNT_W-1:0]  free_cnt;
    logic [CNT_W-1:0]  used_cnt;
  } frame_reply_t;

  // Block ports; every input starts at a known value
  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              cfg_write  = 1'b0;
  logic [CNT_W-1:0]  cfg_data   = '0;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic [1:0]        cmd        = '0;
  logic [PAGE_W-1:0] page_num   = '0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic [PAGE_W-1:0] page_out;
  logic [2:0]        status;
  logic [CNT_W-1:0]  free_count;
  logic [CNT_W-1:0]  used_count;

  // Shadow of the allocator: bitmap, next-fit hint, counters, kernel boundary
  bit          frame_used [PAGES];
  int unsigned hint_page;
  int unsigned free_tally;
  int unsigned used_tally;
  int unsigned kernel_first;

  // Replies still owed by the block, oldest first
  frame_reply_t owed_replies[$];

  // Idle percentages for the input and output sides
  int     send_gap_pct;
  int     stall_pct;
  int     mismatches  = 0;
  longint cycle_count = 0;

  bitmap_page_frame_allocator i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .page_num   (page_num),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .page_out   (page_out),
    .status     (status),
    .free_count (free_count),
    .used_count (used_count)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // Hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Allocator shadow
  // ---------------------------------------------------------------------------

  function automatic void clear_frames();
    foreach (frame_used[i]) frame_used[i] = 1'b0;
    hint_page    = 1;
    free_tally   = PAGES;
    used_tally   = 0;
    kernel_first = PAGES;
  endfunction

  // Take one page; the kernel check wins over range, range over in-use.
  // A successful take moves the hint onto the page.
  function automatic status_t claim_frame(int unsigned pg);
    if (pg >= kernel_first) return ST_KERNEL;
    if (pg >= PAGES) return ST_RANGE;
    if (frame_used[pg]) return ST_IN_USE;
    frame_used[pg] = 1'b1;
    hint_page      = pg;
    free_tally--;
    used_tally++;
    return ST_OK;
  endfunction

  // Give one page back; the kernel region does not matter here
  function automatic status_t release_frame(int unsigned pg);
    if (pg >= PAGES) return ST_RANGE;
    if (!frame_used[pg]) return ST_ALREADY_FREE;
    frame_used[pg] = 1'b0;
    free_tally++;
    used_tally--;
    return ST_OK;
  endfunction

  // Full effect of one command word and the reply it earns
  function automatic frame_reply_t next_fit_step(cmd_t c, logic [PAGE_W-1:0] pg);
    frame_reply_t r;
    int unsigned  chosen;
    status_t      st;
    chosen = pg;
    st     = ST_RANGE;
    case (c)
      CMD_ALLOC_ANY: begin
        // Hint wraps back to 1 at the kernel boundary or the top page
        if (hint_page >= kernel_first || hint_page >= PAGES - 1) hint_page = 1;
        hint_page++;
        chosen = hint_page;
        if (frame_used[chosen]) begin
          // Fall back to the lowest free page above page zero
          chosen = 0;
          for (int i = 1; i < PAGES; i++) begin
            if (!frame_used[i]) begin
              chosen = i;
              break;
            end
          end
          if (chosen != 0) hint_page = chosen;
        end
        // Hint stays at the chosen page even if the take is refused
        st = (chosen == 0) ? ST_OOM : claim_frame(chosen);
      end
      CMD_FREE:     st = release_frame(pg);
      CMD_ALLOC_AT: st = claim_frame(pg);
      default: ;
    endcase
    r.page     = (st == ST_OK) ? PAGE_W'(chosen) : '0;
    r.st       = st;
    r.free_cnt = CNT_W'(free_tally);
    r.used_cnt = CNT_W'(used_tally);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Present one command word and hold it until taken. Valid is left high on
  // return so a back-to-back word needs no drop in between.
  task automatic send_word(input cmd_t c, input logic [PAGE_W-1:0] pg);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    page_num <= pg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    owed_replies.push_back(next_fit_step(c, pg));
  endtask

  // Boundary is only changed with the block drained and idle
  task automatic write_kernel_first(input int unsigned boundary);
    in_valid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
    repeat (IDLE_GUARD) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= CNT_W'(boundary);
    @(posedge clk);
    cfg_write    <= 1'b0;
    kernel_first = boundary;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and in-order checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : reply_check
    frame_reply_t want;
    out_ready <= ($urandom_range(99) >= stall_pct);
    if (!rst && out_valid && out_ready) begin
      if (owed_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("%0t: unexpected word page %0d status %0d free %0d used %0d",
                   $realtime, page_out, status, free_count, used_count);
      end else begin
        want = owed_replies.pop_front();
        if (page_out !== want.page || status !== want.st ||
            free_count !== want.free_cnt || used_count !== want.used_cnt) begin
          mismatches++;
          if (mismatches <= SHOW_MAX)
            $display("%0t: exp/got page %0d/%0d st %0d/%0d free %0d/%0d used %0d/%0d",
                     $realtime, want.page, page_out, want.st, status,
                     want.free_cnt, free_count, want.used_cnt, used_count);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked words: every status code but OOM, page zero, the top page, hint wrap
  // at the top page and at the kernel boundary, scan fallback, unknown command
  task automatic test_directed();
    send_word(CMD_ALLOC_ANY, '0);          // hint path, page 2
    send_word(CMD_ALLOC_AT, '0);           // page zero is allowed
    send_word(CMD_FREE, '0);
    send_word(CMD_FREE, '0);               // already free
    send_word(CMD_ALLOC_AT, '1);           // top page, hint goes to 4095
    send_word(CMD_ALLOC_AT, '1);           // in use
    send_word(CMD_ALLOC_ANY, '1);          // hint wraps, page 2 taken, scan
    send_word(CMD_ALLOC_ANY, '0);          // scan again
    send_word(CMD_NONE, '1);               // unknown command
    send_word(CMD_FREE, '1);
    send_word(CMD_FREE, '1);
    send_word(CMD_ALLOC_AT, 12'd2);        // in use
    // Lowest boundary: everything but page zero is kernel space
    write_kernel_first(1);
    send_word(CMD_ALLOC_ANY, '0);
    send_word(CMD_ALLOC_AT, '0);
    send_word(CMD_ALLOC_AT, '1);
    send_word(CMD_FREE, 12'd3);            // freeing ignores the kernel region
    send_word(CMD_FREE, '0);
    send_word(CMD_NONE, '0);
    // Boundary just above a claimed page
    write_kernel_first(16);
    send_word(CMD_ALLOC_AT, 12'd15);
    send_word(CMD_ALLOC_AT, 12'd16);
    send_word(CMD_ALLOC_ANY, '1);          // hint+1 lands on the boundary
    send_word(CMD_ALLOC_ANY, '0);          // hint wraps from the boundary
  endtask

  // Fill a run of low pages, park the boundary just above it so every
  // allocate-any scans many rows, punch holes for the scan to find, then
  // hand every used page back in a scrambled order
  task automatic test_deep_scan();
    int unsigned top;
    int unsigned hole;
    int unsigned start;
    int unsigned stride;
    int unsigned pg;
    write_kernel_first(PAGES);
    while (used_tally < FILL_PAGES)
      send_word(CMD_ALLOC_ANY, PAGE_W'($urandom));
    send_word(CMD_ALLOC_AT, '0);
    send_word(CMD_ALLOC_AT, '0);
    // First free page above zero becomes the kernel boundary
    top = 1;
    while (frame_used[top]) top++;
    write_kernel_first(top);
    send_word(CMD_ALLOC_ANY, PAGE_W'($urandom));
    repeat (6) begin
      hole = $urandom_range(top - 1, 1);
      send_word(CMD_FREE, PAGE_W'(hole));
      send_word(CMD_ALLOC_ANY, PAGE_W'($urandom));   // scan finds the hole
      send_word(CMD_ALLOC_ANY, PAGE_W'($urandom));   // scan ends at the boundary
    end
    // Odd stride walks all pages exactly once
    start  = $urandom_range(PAGES - 1);
    stride = $urandom_range(PAGES / 2 - 1) * 2 + 1;
    for (int k = 0; k < PAGES; k++) begin
      pg = (start + k * stride) % PAGES;
      if (frame_used[pg]) send_word(CMD_FREE, PAGE_W'(pg));
    end
  endtask

  // Random traffic steered toward an occupancy level, with some noise words
  task automatic test_random_mix(input int unsigned boundary, input int unsigned target,
                                 input int words);
    cmd_t              c;
    logic [PAGE_W-1:0] pg;
    int unsigned       r;
    int unsigned       probe;
    write_kernel_first(boundary);
    repeat (words) begin
      r  = $urandom_range(99);
      pg = PAGE_W'($urandom);
      if (r < 12) begin
        c = cmd_t'($urandom_range(3));
      end else if (used_tally < target) begin
        if (r < 70) begin
          c = CMD_ALLOC_ANY;
        end else begin
          c = CMD_ALLOC_AT;
          if (r < 85 && boundary > 1) pg = PAGE_W'($urandom_range(boundary - 1));
        end
      end else begin
        // Free a page that is actually in use, if there is one
        c     = CMD_FREE;
        probe = pg;
        for (int k = 0; k < PAGES; k++) begin
          if (frame_used[(probe + k) % PAGES]) begin
            pg = PAGE_W'(probe + k);
            break;
          end
        end
      end
      send_word(c, pg);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    clear_frames();
    send_gap_pct = 19;
    stall_pct    = 63;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_deep_scan();
    test_random_mix(PAGES, 24, 80);
    test_random_mix($urandom_range(PAGES - 2, 2), 300, 80);

    send_gap_pct = 63;
    stall_pct    = 19;
    test_random_mix(1, 0, 40);
    test_random_mix(64, 48, 80);

    send_gap_pct = 0;
    stall_pct    = 0;
    test_random_mix(200, 260, 80);
    test_random_mix(PAGES - 1, 30, 40);

    in_valid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
    // Catch any stray word after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

/* files.f */
hdl/bpfa_pkg.sv
hdl/bpfa_ctrl.sv
hdl/bpfa_dp.sv
hdl/bitmap_page_frame_allocator.sv
tb/sv/testbench.sv
